// ===== rtl/ssra_pkg.sv =====
// shared types and constants of the swap slot reference count allocator
package ssra_pkg;

	localparam int CNT_W     = 13;
	localparam int SLOT_W    = 12;
	localparam int REF_W     = 16;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int MAX_SLOTS_DEF = 4096;

	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 13'd4096;
	localparam logic [REF_W-1:0] SLOT_UNUSED    = 16'hFFFF;
	localparam logic [REF_W-1:0] SLOT_MAX_REF   = 16'hFFFE;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DUP   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REM   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_QRY   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FREE  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAIL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_ALLOC,
		S_SCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic accept;
		logic exec_fire;
		logic alloc_setup;
		logic scan;
		logic fin_fire;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_alloc;
		logic lim_small;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/ssra_ram.sv =====
// generic simple dual port ram, one write and one registered read port
module ssra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ssra_ctrl.sv =====
// controller state machine of the slot allocator
module ssra_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  ssra_pkg::dp_stat_t    stat,
	output ssra_pkg::ctrl_cmd_t   cmd
);

	ssra_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssra_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ssra_pkg::S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_d = ssra_pkg::S_IDLE;
				end
			end
			ssra_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d = stat.in_alloc ? ssra_pkg::S_ALLOC : ssra_pkg::S_EXEC;
				end
			end
			ssra_pkg::S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec_fire = 1'b1;
					state_d = ssra_pkg::S_IDLE;
				end
			end
			ssra_pkg::S_ALLOC: begin
				cmd.alloc_setup = 1'b1;
				state_d = stat.lim_small ? ssra_pkg::S_FIN : ssra_pkg::S_SCAN;
			end
			ssra_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = ssra_pkg::S_FIN;
				end
			end
			ssra_pkg::S_FIN: begin
				if (stat.out_free) begin
					cmd.fin_fire = 1'b1;
					state_d = ssra_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ssra_pkg::S_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/ssra_dp.sv =====
// datapath: count table, scan pointer, count update and result register
module ssra_dp #(
	parameter int MAX_SLOTS = ssra_pkg::MAX_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssra_pkg::ctrl_cmd_t           cmd,
	output ssra_pkg::dp_stat_t            stat,
	input  logic                          cfg_valid,
	input  logic [ssra_pkg::CNT_W-1:0]    cfg_data,
	input  logic [ssra_pkg::ACT_W-1:0]    in_action,
	input  logic [ssra_pkg::SLOT_W-1:0]   in_slot,
	input  logic                          in_page_in_use,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ssra_pkg::STAT_W-1:0]   out_status,
	output logic [ssra_pkg::SLOT_W-1:0]   out_slot,
	output logic [ssra_pkg::REF_W-1:0]    out_ref_count,
	output logic                          out_slot_unused,
	output logic                          out_reclaimed
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int LIM_W = (ssra_pkg::CNT_W > $clog2(MAX_SLOTS + 1)) ?
		ssra_pkg::CNT_W : $clog2(MAX_SLOTS + 1);
	localparam logic [LIM_W-1:0] MAX_EXT = LIM_W'(MAX_SLOTS);
	localparam logic [AW-1:0] CLR_END = AW'(MAX_SLOTS - 1);
	localparam logic [AW-1:0] FIRST_SLOT = AW'(1);

	logic [ssra_pkg::CNT_W-1:0]  slot_count_q;
	logic [AW-1:0]               clr_q;
	logic [ssra_pkg::ACT_W-1:0]  act_q;
	logic [ssra_pkg::SLOT_W-1:0] slot_q;
	logic                        in_use_q;
	logic [AW-1:0]               ptr_q;
	logic [AW-1:0]               start_q;
	logic [AW-1:0]               iss_q;
	logic [AW-1:0]               chk_q;
	logic [AW-1:0]               zero_q;
	logic [AW-1:0]               empty_q;
	logic [AW-1:0]               ptr_nxt_q;
	logic                        m_tvalid_q;

	logic [LIM_W-1:0]            cnt_ext;
	logic [LIM_W-1:0]            lim;
	logic [AW-1:0]               p0;
	logic [AW-1:0]               chk_nxt;
	logic [AW-1:0]               pick;
	logic [ssra_pkg::REF_W-1:0]  v;
	logic                        v_unused;
	logic [ssra_pkg::REF_W-1:0]  v_inc;
	logic [ssra_pkg::REF_W-1:0]  v_dec;
	logic                        in_range;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [ssra_pkg::REF_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;

	logic                        ex_we;
	logic [ssra_pkg::REF_W-1:0]  ex_wdata;
	logic [ssra_pkg::STAT_W-1:0] ex_status;
	logic [ssra_pkg::REF_W-1:0]  ex_ref;
	logic                        ex_unused;

	// circular successor over slots 1 .. limit-1
	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] x,
		input logic [LIM_W-1:0] l);
		logic [LIM_W-1:0] inc;
		inc = LIM_W'(x) + LIM_W'(1);
		return (inc == l) ? FIRST_SLOT : AW'(inc);
	endfunction

	ssra_ram #(
		.WIDTH(ssra_pkg::REF_W),
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (v)
	);

	assign cnt_ext  = LIM_W'(slot_count_q);
	assign lim      = (cnt_ext < MAX_EXT) ? cnt_ext : MAX_EXT;
	assign p0       = (ptr_q == '0 || LIM_W'(ptr_q) >= lim) ? FIRST_SLOT : ptr_q;
	assign chk_nxt  = next_slot(chk_q, lim);
	assign pick     = (empty_q != '0) ? empty_q : zero_q;
	assign v_unused = (v == ssra_pkg::SLOT_UNUSED);
	assign v_inc    = v + 16'd1;
	assign v_dec    = v - 16'd1;
	assign in_range = LIM_W'(slot_q) < lim;

	assign stat.clr_last  = (clr_q == CLR_END);
	assign stat.in_alloc  = (in_action == ssra_pkg::ACT_ALLOC);
	assign stat.lim_small = lim < LIM_W'(2);
	assign stat.scan_done = v_unused || (chk_nxt == start_q);
	assign stat.out_free  = !m_tvalid_q || m_tready;

	// count update for actions other than allocate
	always_comb begin
		ex_we     = 1'b0;
		ex_wdata  = v;
		ex_status = ssra_pkg::ST_OK;
		ex_ref    = v_unused ? '0 : v;
		ex_unused = v_unused;
		if (act_q > ssra_pkg::ACT_FREE || act_q == ssra_pkg::ACT_ALLOC) begin
			ex_status = ssra_pkg::ST_ILLEGAL;
			ex_ref    = '0;
			ex_unused = 1'b0;
		end else if (!in_range) begin
			ex_status = ssra_pkg::ST_ILLEGAL;
			ex_ref    = '0;
			ex_unused = 1'b1;
		end else begin
			case (act_q)
				ssra_pkg::ACT_DUP: begin
					if (v >= ssra_pkg::SLOT_MAX_REF) begin
						ex_status = ssra_pkg::ST_ILLEGAL;
					end else begin
						ex_we    = 1'b1;
						ex_wdata = v_inc;
						ex_ref   = v_inc;
					end
				end
				ssra_pkg::ACT_REM: begin
					if (v == '0 || v_unused) begin
						ex_status = ssra_pkg::ST_ILLEGAL;
						ex_ref    = '0;
					end else if (v_dec == '0 && !in_use_q) begin
						ex_we     = 1'b1;
						ex_wdata  = ssra_pkg::SLOT_UNUSED;
						ex_ref    = '0;
						ex_unused = 1'b1;
					end else begin
						ex_we    = 1'b1;
						ex_wdata = v_dec;
						ex_ref   = v_dec;
					end
				end
				ssra_pkg::ACT_QRY: begin
					ex_status = ssra_pkg::ST_OK;
				end
				default: begin
					// free if zero
					if (v == '0) begin
						ex_we     = 1'b1;
						ex_wdata  = ssra_pkg::SLOT_UNUSED;
						ex_unused = 1'b1;
					end else begin
						ex_status = ssra_pkg::ST_FAIL;
					end
				end
			endcase
		end
	end

	// table port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = ssra_pkg::SLOT_UNUSED;
		if (cmd.clr_en) begin
			ram_we = 1'b1;
		end else if (cmd.exec_fire) begin
			ram_we    = ex_we && in_range;
			ram_waddr = AW'(slot_q);
			ram_wdata = ex_wdata;
		end else if (cmd.fin_fire) begin
			ram_we    = (pick != '0);
			ram_waddr = pick;
			ram_wdata = '0;
		end
		ram_re    = cmd.accept || cmd.alloc_setup || cmd.scan;
		ram_raddr = iss_q;
		if (cmd.accept) begin
			ram_raddr = AW'(in_slot);
		end else if (cmd.alloc_setup) begin
			ram_raddr = p0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= ssra_pkg::SLOT_COUNT_RST;
			clr_q        <= '0;
			ptr_q        <= FIRST_SLOT;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				slot_count_q <= cfg_data;
			end
			if (cmd.clr_en) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.fin_fire) begin
				ptr_q <= ptr_nxt_q;
			end
			if (cmd.exec_fire || cmd.fin_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request and scan registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q    <= in_action;
			slot_q   <= in_slot;
			in_use_q <= in_page_in_use;
		end
		if (cmd.alloc_setup) begin
			start_q   <= p0;
			chk_q     <= p0;
			iss_q     <= next_slot(p0, lim);
			zero_q    <= '0;
			empty_q   <= '0;
			ptr_nxt_q <= ptr_q;
		end
		if (cmd.scan) begin
			// read data of chk_q arrives while iss_q is being fetched
			chk_q <= iss_q;
			iss_q <= next_slot(iss_q, lim);
			if (v == '0 && zero_q == '0) begin
				zero_q <= chk_q;
			end
			if (v_unused) begin
				empty_q   <= chk_q;
				ptr_nxt_q <= chk_nxt;
			end else if (chk_nxt == start_q) begin
				ptr_nxt_q <= start_q;
			end
		end
		if (cmd.exec_fire) begin
			out_status      <= ex_status;
			out_slot        <= '0;
			out_ref_count   <= ex_ref;
			out_slot_unused <= ex_unused;
			out_reclaimed   <= 1'b0;
		end else if (cmd.fin_fire) begin
			out_status      <= (pick != '0) ? ssra_pkg::ST_OK : ssra_pkg::ST_FAIL;
			out_slot        <= ssra_pkg::SLOT_W'(pick);
			out_ref_count   <= '0;
			out_slot_unused <= 1'b0;
			out_reclaimed   <= (empty_q == '0) && (zero_q != '0);
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ===== rtl/swap_slot_refcount_allocator_unit.sv =====
// top level of the swap slot reference count allocator
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser action, tdata slot + page_in_use
// m_*       out  m_tvalid/m_tready   tdata status, slot_out, ref_count, flags
// cfg_*     in   cfg_valid/cfg_ready cfg_data slot_count
//
// duplicate, remove, query and free each do one table read, then
// the update and write back on the single write port of the count table.
// allocate visits slots with a next-fit scan
// (one table read per cycle, up to limit-1 slots).
// after reset a clearing pass marks every slot unused;
// no request is taken meanwhile, configuration writes are.
// a result waiting on m_tready stalls the block before its next write back.
module swap_slot_refcount_allocator_unit #(
	parameter int MAX_SLOTS = ssra_pkg::MAX_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,   // slot[11:0], page_in_use[12]
	input  logic [ssra_pkg::ACT_W-1:0] s_tuser,   // action[2:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status[1:0], slot_out[13:2], ref_count[29:14], slot_unused[30], reclaimed[31]
	output logic [31:0]                m_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ssra_pkg::CNT_W-1:0] cfg_data
);

	ssra_pkg::ctrl_cmd_t cmd;
	ssra_pkg::dp_stat_t  stat;

	logic [ssra_pkg::STAT_W-1:0] out_status;
	logic [ssra_pkg::SLOT_W-1:0] out_slot;
	logic [ssra_pkg::REF_W-1:0]  out_ref_count;
	logic                        out_slot_unused;
	logic                        out_reclaimed;

	assign cfg_ready = 1'b1;

	ssra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssra_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.in_action       (s_tuser),
		.in_slot         (s_tdata[11:0]),
		.in_page_in_use  (s_tdata[12]),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.out_status      (out_status),
		.out_slot        (out_slot),
		.out_ref_count   (out_ref_count),
		.out_slot_unused (out_slot_unused),
		.out_reclaimed   (out_reclaimed)
	);

	assign m_tdata = {out_reclaimed, out_slot_unused, out_ref_count, out_slot, out_status};

endmodule

// ===== rtl/ssra_checker.sv =====
// port level checks of the slot allocator, bound to the top level
module ssra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	// a reclaim is always a successful allocation of a real slot
	a_reclaim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31] |->
			m_tdata[1:0] == ssra_pkg::ST_OK && m_tdata[13:2] != 12'd0 && !m_tdata[30])
		else $error("reclaim flag on a bad allocation");

	a_unused_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[30] |-> m_tdata[29:14] == 16'd0)
		else $error("unused slot with nonzero count");

endmodule

bind swap_slot_refcount_allocator_unit ssra_checker u_ssra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/tb_swap_slot_refcount_allocator_unit.sv =====
// self-checking testbench for the swap slot reference count allocator
`timescale 1ns / 1ps

module tb_swap_slot_refcount_allocator_unit;
	import ssra_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNDEF_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_UNDEF_LAST  = 3'd7;
	localparam int GRANT_KEEP = 48;

	// same layout as m_tdata: status in the lowest bits
	typedef struct packed {
		logic              reclaimed;
		logic              slot_unused;
		logic [REF_W-1:0]  ref_count;
		logic [SLOT_W-1:0] slot_out;
		logic [STAT_W-1:0] status;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;   // slot[11:0], page_in_use[12]
	logic [ACT_W-1:0]  s_tuser = '0;   // action[2:0]
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	// status[1:0], slot_out[13:2], ref_count[29:14], slot_unused[30], reclaimed[31]
	logic [31:0]       m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;

	// shadow of the count table, scan pointer and slot_count register
	logic [REF_W-1:0]  count_tbl [MAX_SLOTS_DEF];
	int                scan_ptr;
	logic [CNT_W-1:0]  slot_count_reg;

	result_t           pending_results [$];
	logic [SLOT_W-1:0] granted_slots [$];
	result_t           last_result;
	int                sender_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                fail_count = 0;

	swap_slot_refcount_allocator_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t next_slot_result(input logic [ACT_W-1:0] act,
			input logic [SLOT_W-1:0] slot, input logic page_busy);
		result_t          r;
		int               lim;
		int               p;
		int               start_at;
		int               empty_at;
		int               zero_at;
		int               pick;
		int               n;
		logic [REF_W-1:0] v;
		logic             unused;
		r = '0;
		lim = (int'(slot_count_reg) < MAX_SLOTS_DEF) ? int'(slot_count_reg) : MAX_SLOTS_DEF;
		if (act == ACT_ALLOC) begin
			if (lim < 2) begin
				r.status = ST_FAIL;
				return r;
			end
			p = scan_ptr;
			if (p == 0 || p >= lim)
				p = 1;
			start_at = p;
			empty_at = 0;
			zero_at = 0;
			// next-fit: one full turn over slots 1 .. lim-1 at most
			for (n = 0; n < lim - 1 && empty_at == 0; n++) begin
				if (count_tbl[p] == SLOT_UNUSED)
					empty_at = p;
				else if (count_tbl[p] == '0 && zero_at == 0)
					zero_at = p;
				p++;
				if (p == lim)
					p = 1;
			end
			scan_ptr = p;
			pick = (empty_at != 0) ? empty_at : zero_at;
			if (pick == 0) begin
				r.status = ST_FAIL;
				return r;
			end
			count_tbl[pick] = '0;
			r.status = ST_OK;
			r.slot_out = pick[SLOT_W-1:0];
			r.reclaimed = (empty_at == 0);
			return r;
		end
		if (act > ACT_FREE) begin
			r.status = ST_ILLEGAL;
			return r;
		end
		if (int'(slot) >= lim) begin
			r.status = ST_ILLEGAL;
			r.slot_unused = 1'b1;
			return r;
		end
		v = count_tbl[slot];
		unused = (v == SLOT_UNUSED);
		case (act)
			ACT_DUP: begin
				if (v >= SLOT_MAX_REF) begin
					r.status = ST_ILLEGAL;
					r.ref_count = unused ? '0 : v;
					r.slot_unused = unused;
				end else begin
					v = v + 1'b1;
					count_tbl[slot] = v;
					r.status = ST_OK;
					r.ref_count = v;
				end
			end
			ACT_REM: begin
				if (v == '0 || unused) begin
					r.status = ST_ILLEGAL;
					r.slot_unused = unused;
				end else begin
					v = v - 1'b1;
					r.status = ST_OK;
					// a still-referenced cached page keeps the slot at zero, in use
					if (v == '0 && !page_busy) begin
						count_tbl[slot] = SLOT_UNUSED;
						r.slot_unused = 1'b1;
					end else begin
						count_tbl[slot] = v;
						r.ref_count = v;
					end
				end
			end
			ACT_QRY: begin
				r.status = ST_OK;
				r.ref_count = unused ? '0 : v;
				r.slot_unused = unused;
			end
			ACT_FREE: begin
				if (v == '0) begin
					count_tbl[slot] = SLOT_UNUSED;
					r.status = ST_OK;
					r.slot_unused = 1'b1;
				end else begin
					r.status = ST_FAIL;
					r.ref_count = unused ? '0 : v;
					r.slot_unused = unused;
				end
			end
			default: begin
				r.status = ST_ILLEGAL;
			end
		endcase
		return r;
	endfunction

	task automatic send_req(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] slot,
			input logic page_busy);
		result_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, page_busy, slot};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = next_slot_result(act, slot, page_busy);
		pending_results.push_back(r);
		last_result = r;
		if (act == ACT_ALLOC && r.status == ST_OK) begin
			granted_slots.push_back(r.slot_out);
			if (granted_slots.size() > GRANT_KEEP)
				void'(granted_slots.pop_front());
		end
		@(negedge clk);
	endtask

	// called at a falling edge; holds off requests until every result is back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_slot_count(input logic [CNT_W-1:0] value);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		slot_count_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_field(input string name, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
		fail_count++;
	endtask

	// the receiver stalls at random, changing ready at the falling edge
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_field("status", 32'(want.status), 32'(got.status));
				if (got.slot_out !== want.slot_out)
					report_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
				if (got.ref_count !== want.ref_count)
					report_field("ref_count", 32'(want.ref_count), 32'(got.ref_count));
				if (got.slot_unused !== want.slot_unused)
					report_field("slot_unused", 32'(want.slot_unused),
						32'(got.slot_unused));
				if (got.reclaimed !== want.reclaimed)
					report_field("reclaimed", 32'(want.reclaimed), 32'(got.reclaimed));
			end
		end
	end

	task automatic test_basic_actions();
		logic [ACT_W-1:0] act;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		write_slot_count(13'd4096);
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		send_req(ACT_DUP, 12'd1, 1'b0);
		send_req(ACT_DUP, 12'd1, 1'b1);
		send_req(ACT_QRY, 12'd1, 1'b0);
		send_req(ACT_REM, 12'd1, 1'b1);
		// reaches zero with a cached page still referenced
		send_req(ACT_REM, 12'd1, 1'b1);
		send_req(ACT_REM, 12'd1, 1'b0);
		send_req(ACT_FREE, 12'd1, 1'b0);
		send_req(ACT_FREE, 12'd1, 1'b0);
		send_req(ACT_REM, 12'd1, 1'b0);
		send_req(ACT_DUP, 12'd1, 1'b0);
		send_req(ACT_QRY, 12'd0, 1'b0);
		send_req(ACT_QRY, 12'd4095, 1'b1);
		send_req(ACT_DUP, 12'd0, 1'b0);
		send_req(ACT_ALLOC, 12'd4095, 1'b1);
		send_req(ACT_DUP, 12'd2, 1'b0);
		send_req(ACT_FREE, 12'd2, 1'b0);
		send_req(ACT_REM, 12'd2, 1'b0);
		for (act = ACT_UNDEF_FIRST; act != ACT_ALLOC; act++)
			send_req(act, 12'd4095, 1'b1);
	endtask

	task automatic test_small_tables();
		int s;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		// tables too small to hold any slot
		write_slot_count(13'd1);
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		send_req(ACT_QRY, 12'd0, 1'b0);
		send_req(ACT_DUP, 12'd1, 1'b0);
		write_slot_count(13'd0);
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		send_req(ACT_QRY, 12'd0, 1'b0);
		write_slot_count(13'd6);
		for (s = 0; s < 5; s++)
			send_req(ACT_ALLOC, 12'd0, 1'b0);
		// table full, all counts zero: reclaim
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		for (s = 1; s < 6; s++)
			send_req(ACT_DUP, s[SLOT_W-1:0], 1'b0);
		// no unused and no zero-count slot left
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		send_req(ACT_REM, 12'd4, 1'b1);
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		// scan pointer now lies beyond the table
		write_slot_count(13'd2);
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		send_req(ACT_DUP, 12'd5, 1'b0);
		write_slot_count(13'd8191);
		send_req(ACT_QRY, 12'd4095, 1'b0);
	endtask

	task automatic test_count_climb();
		logic [SLOT_W-1:0] slot;
		int                n;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		send_req(ACT_ALLOC, 12'd0, 1'b0);
		slot = last_result.slot_out;
		for (n = 0; n < 20; n++)
			send_req(ACT_DUP, slot, 1'b0);
		send_req(ACT_QRY, slot, 1'b0);
		for (n = 0; n < 20; n++)
			send_req(ACT_REM, slot, 1'b1);
		// count back at zero and kept in use by the cached page
		send_req(ACT_REM, slot, 1'b0);
		send_req(ACT_FREE, slot, 1'b0);
		send_req(ACT_QRY, slot, 1'b0);
	endtask

	task automatic test_random_traffic(input logic [CNT_W-1:0] count, input int idle,
			input int stall, input int n_req);
		int                k;
		int                roll;
		logic [ACT_W-1:0]  act;
		logic [SLOT_W-1:0] slot;
		write_slot_count(count);
		granted_slots.delete();
		sender_idle_pct = idle;
		recv_stall_pct = stall;
		for (k = 0; k < n_req; k++) begin
			roll = $urandom_range(99);
			if (roll < 20) begin
				send_req(ACT_ALLOC, SLOT_W'($urandom_range(4095)), 1'($urandom_range(1)));
			end else if (roll < 80 && granted_slots.size() != 0) begin
				// well-formed traffic on slots handed out earlier
				slot = granted_slots[$urandom_range(granted_slots.size() - 1)];
				roll = $urandom_range(99);
				if (roll < 40)
					act = ACT_DUP;
				else if (roll < 70)
					act = ACT_REM;
				else if (roll < 85)
					act = ACT_QRY;
				else
					act = ACT_FREE;
				send_req(act, slot, 1'($urandom_range(1)));
			end else begin
				send_req(ACT_W'($urandom_range(7)), SLOT_W'($urandom_range(4095)),
					1'($urandom_range(1)));
			end
			if (k == n_req / 2)
				wait_drain();
		end
	endtask

	initial begin : main
		int i;
		for (i = 0; i < MAX_SLOTS_DEF; i++)
			count_tbl[i] = SLOT_UNUSED;
		scan_ptr = 1;
		slot_count_reg = SLOT_COUNT_RST;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_basic_actions();
		test_small_tables();
		test_count_climb();
		test_random_traffic(13'd4096, 0, 0, 140);
		test_random_traffic(13'd1024, 79, 0, 140);
		test_random_traffic(CNT_W'($urandom_range(4096, 1024)), 0, 79, 140);
		test_random_traffic(13'd12, 24, 24, 150);
		wait_drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#200_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ssra_pkg.sv
rtl/ssra_ram.sv
rtl/ssra_ctrl.sv
rtl/ssra_dp.sv
rtl/swap_slot_refcount_allocator_unit.sv
rtl/ssra_checker.sv
tb/sv/tb_swap_slot_refcount_allocator_unit.sv
